[src/row_softmax_engine_defines.svh]
// ----------------------------------------------------------------------------
// Row softmax engine assertion macros
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ROW_SOFTMAX_ENGINE_DEFINES_SVH
`define ROW_SOFTMAX_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define RSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define RSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[src/rse_pkg.sv]
// ----------------------------------------------------------------------------
// Row softmax engine package
// Item types, controller/datapath bundles, constants and exp factor function.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int IDX_W              = 10;
    localparam int SMP_W              = 16;
    localparam int PROB_W             = 16;
    localparam int LEN_REG_W          = 11;
    localparam int SUM_W              = 27;
    localparam int EXP_SPAN_BITS      = 12;
    localparam int DEF_MAX_ROW_LEN    = 1024;
    localparam int DEF_EXP_TABLE_BITS = 10;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;

    localparam logic [LEN_REG_W-1:0] ROW_LEN_RESET = 11'd1024;
    localparam logic [31:0]          EXP_C0        = 32'd4278222805;
    localparam logic                 REQ_LOAD      = 1'b0;
    localparam logic                 REQ_READ      = 1'b1;
    localparam logic                 REG_ROW_LEN   = 1'b0;

    typedef struct packed {
        logic                    req_type;
        logic [IDX_W-1:0]        elem_index;
        logic signed [SMP_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [PROB_W-1:0] prob;
        logic [IDX_W-1:0]  result_index;
        logic              not_ready;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic pass_start;
        logic prd;
        logic pld;
        logic exp_step;
        logic pwr;
        logic rrd;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_load;
        logic in_last;
        logic in_div_ok;
        logic exp_last;
        logic pass_last;
        logic div_busy;
        logic out_free;
        logic sum_nz;
    } t_st;

    // Q0.32 factor exp(-2^b/256), by repeated rounded squaring
    function automatic logic [31:0] exp_factor(input int b);
        logic [63:0] f;
        f = 64'(EXP_C0);
        for (int i = 0; i < b; i++) begin
            f = (f * f + 64'h8000_0000) >> 32;
        end
        return f[31:0];
    endfunction

endpackage

[src/rse_div.sv]
// ----------------------------------------------------------------------------
// Row softmax engine divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rse_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rse_pkg::SUM_W+5:0] i_num,
    input  logic [rse_pkg::SUM_W-1:0] i_den,
    output logic                      o_busy,
    output logic [rse_pkg::SUM_W+5:0] o_quo
);
    import rse_pkg::*;

    localparam int NUM_W = SUM_W + 6;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [SUM_W-1:0] r_rem, r_den;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W:0]   w_sh;
    logic             w_ge;
    logic [SUM_W:0]   w_diff;

    assign w_sh   = {r_rem, r_quo[NUM_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[SUM_W-1:0] : w_sh[SUM_W-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quo  = r_quo;
endmodule

[src/rse_ctrl.sv]
// ----------------------------------------------------------------------------
// Row softmax engine controller
// Sequences loads, the exp/sum pass over a row and normalised reads.
// ----------------------------------------------------------------------------
module rse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rse_pkg::t_st  i_st,
    output rse_pkg::t_cmd o_cmd
);
    import rse_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PRD  = 4'd1;
    localparam logic [3:0] S_PLD  = 4'd2;
    localparam logic [3:0] S_PEXP = 4'd3;
    localparam logic [3:0] S_PWR  = 4'd4;
    localparam logic [3:0] S_RRD  = 4'd5;
    localparam logic [3:0] S_RLD  = 4'd6;
    localparam logic [3:0] S_RDIV = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.in_load) begin
                        if (i_st.in_last) begin
                            o_cmd.pass_start = 1'b1;
                            n_state          = S_PRD;
                        end
                    end else if (i_st.in_div_ok) begin
                        n_state = S_RRD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_PRD: begin
                o_cmd.prd = 1'b1;
                n_state   = S_PLD;
            end
            S_PLD: begin
                o_cmd.pld = 1'b1;
                n_state   = S_PEXP;
            end
            S_PEXP: begin
                o_cmd.exp_step = 1'b1;
                if (i_st.exp_last) begin
                    n_state = S_PWR;
                end
            end
            S_PWR: begin
                o_cmd.pwr = 1'b1;
                n_state   = i_st.pass_last ? S_IDLE : S_PRD;
            end
            S_RRD: begin
                o_cmd.rrd = 1'b1;
                n_state   = S_RLD;
            end
            S_RLD: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_RDIV;
            end
            S_RDIV: begin
                if (!i_st.div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = r_state == S_IDLE;
endmodule

[src/rse_dp.sv]
// ----------------------------------------------------------------------------
// Row softmax engine datapath
// Sample and exp stores, running max, exp unit, row sum, divider, output reg.
// ----------------------------------------------------------------------------
module rse_dp #(
    parameter int MAX_ROW_LEN    = rse_pkg::DEF_MAX_ROW_LEN,
    parameter int EXP_TABLE_BITS = rse_pkg::DEF_EXP_TABLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rse_pkg::t_in_item             i_in_data,
    input  logic [rse_pkg::LEN_REG_W-1:0] i_row_length,
    input  rse_pkg::t_cmd                 i_cmd,
    output rse_pkg::t_st                  o_st,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rse_pkg::t_out_item            o_out_data
);
    import rse_pkg::*;

    localparam int AW    = $clog2(MAX_ROW_LEN);
    localparam int LW    = $clog2(MAX_ROW_LEN + 1);
    localparam int CW    = (LW > LEN_REG_W) ? LW : LEN_REG_W;
    localparam int IW    = (LW > IDX_W) ? LW : IDX_W;
    localparam int SHIFT = EXP_SPAN_BITS - EXP_TABLE_BITS;
    localparam int BW    = $clog2(EXP_SPAN_BITS);
    localparam logic [EXP_SPAN_BITS-1:0] D_MASK = {EXP_SPAN_BITS{1'b1}} << SHIFT;

    // Stores
    logic signed [SMP_W-1:0]  r_smp_mem [MAX_ROW_LEN];
    logic [PROB_W-1:0]        r_exp_mem [MAX_ROW_LEN];
    logic signed [SMP_W-1:0]  r_smp_rd;
    logic [PROB_W-1:0]        r_exp_rd;

    logic signed [SMP_W-1:0]  r_max;
    logic [SUM_W-1:0]         r_sum;
    logic                     r_row_done;
    logic [AW-1:0]            r_pidx;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_use_div;

    // Exp unit
    logic [EXP_SPAN_BITS-1:0] r_d;
    logic [BW-1:0]            r_bit;
    logic                     r_one, r_zero;
    logic [31:0]              r_acc;
    logic [31:0]              w_fac [EXP_SPAN_BITS];
    logic [31:0]              w_fac_sel;
    logic [63:0]              w_rnd;
    logic signed [SMP_W:0]    w_d;
    logic [32:0]              w_r;
    logic [PROB_W-1:0]        w_e;
    logic [SUM_W:0]           w_sum_add;

    logic [CW-1:0]            w_len_ext;
    logic [CW-1:0]            w_len;
    logic [AW-1:0]            w_len_m1;
    logic                     w_idx_ok;
    logic                     w_load_ok;

    logic                     w_div_busy;
    logic [SUM_W+5:0]         w_quo;
    logic [SUM_W+5:0]         w_num;

    logic                     r_out_valid;
    t_out_item                r_out;

    for (genvar g = 0; g < EXP_SPAN_BITS; g++) begin : g_fac
        assign w_fac[g] = exp_factor(g);
    end

    // Row length clamp: zero acts as one, oversize saturates
    assign w_len_ext = CW'(i_row_length);
    always_comb begin
        if (w_len_ext == '0) begin
            w_len = CW'(1);
        end else if (w_len_ext > CW'(MAX_ROW_LEN)) begin
            w_len = CW'(MAX_ROW_LEN);
        end else begin
            w_len = w_len_ext;
        end
    end
    assign w_len_m1 = AW'(w_len - CW'(1));

    assign w_idx_ok  = IW'(i_in_data.elem_index) < IW'(MAX_ROW_LEN);
    assign w_load_ok = i_cmd.accept && (i_in_data.req_type == REQ_LOAD) && w_idx_ok;

    assign o_st.in_load   = i_in_data.req_type == REQ_LOAD;
    assign o_st.in_last   = w_idx_ok && (AW'(i_in_data.elem_index) == w_len_m1);
    assign o_st.in_div_ok = r_row_done && w_idx_ok && (r_sum != '0);
    assign o_st.exp_last  = r_bit == BW'(EXP_SPAN_BITS - 1);
    assign o_st.pass_last = r_pidx == w_len_m1;
    assign o_st.div_busy  = w_div_busy;
    assign o_st.out_free  = !r_out_valid || i_out_ready;
    assign o_st.sum_nz    = r_sum != '0;

    // Memories
    always_ff @(posedge i_clk) begin
        if (w_load_ok) begin
            r_smp_mem[AW'(i_in_data.elem_index)] <= i_in_data.sample;
        end
        if (i_cmd.prd) begin
            r_smp_rd <= r_smp_mem[r_pidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pwr) begin
            r_exp_mem[r_pidx] <= w_e;
        end
        if (i_cmd.rrd) begin
            r_exp_rd <= r_exp_mem[AW'(r_idx)];
        end
    end

    // Exp: d = max - x, clamp negative to zero, cut to table resolution
    assign w_d       = {r_max[SMP_W-1], r_max} - {r_smp_rd[SMP_W-1], r_smp_rd};
    assign w_fac_sel = w_fac[r_bit];
    assign w_rnd     = r_acc * w_fac_sel + 64'h8000_0000;
    assign w_r       = {1'b0, r_acc} + 33'h0_8000;

    always_comb begin
        if (r_zero) begin
            w_e = '0;
        end else if (r_one || (w_r[32:16] > 17'(16'hFFFF))) begin
            w_e = 16'hFFFF;
        end else begin
            w_e = w_r[31:16];
        end
    end

    assign w_sum_add = {1'b0, r_sum} + (SUM_W + 1)'(w_e);

    always_ff @(posedge i_clk) begin
        if (i_cmd.pld) begin
            r_bit  <= BW'(SHIFT);
            r_one  <= 1'b1;
            r_zero <= !w_d[SMP_W] && (w_d[SMP_W-1:EXP_SPAN_BITS] != '0);
            r_d    <= w_d[SMP_W] ? '0 : (w_d[EXP_SPAN_BITS-1:0] & D_MASK);
        end else if (i_cmd.exp_step) begin
            r_bit <= r_bit + BW'(1);
            if (r_d[r_bit]) begin
                r_one <= 1'b0;
                r_acc <= r_one ? w_fac_sel : w_rnd[63:32];
            end
        end
    end

    // Control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max      <= {1'b1, {(SMP_W-1){1'b0}}};
            r_sum      <= '0;
            r_row_done <= 1'b0;
            r_pidx     <= '0;
        end else begin
            if (w_load_ok && (i_in_data.sample > r_max)) begin
                r_max <= i_in_data.sample;
            end
            if (i_cmd.pass_start) begin
                r_sum  <= '0;
                r_pidx <= '0;
            end
            if (i_cmd.pwr) begin
                r_sum  <= w_sum_add[SUM_W] ? {SUM_W{1'b1}} : w_sum_add[SUM_W-1:0];
                r_pidx <= r_pidx + AW'(1);
                if (o_st.pass_last) begin
                    r_row_done <= 1'b1;
                    r_max      <= {1'b1, {(SMP_W-1){1'b0}}};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx     <= i_in_data.elem_index;
            r_use_div <= o_st.in_div_ok;
        end
    end

    // Divide (e << 16) + sum/2 by sum for rounding
    assign w_num = (SUM_W + 6)'({r_exp_rd, 16'h0000}) + (SUM_W + 6)'(r_sum >> 1);

    rse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_sum),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.result_index <= r_idx;
            r_out.not_ready    <= !r_row_done;
            if (!r_use_div) begin
                r_out.prob <= '0;
            end else if (w_quo[SUM_W+5:PROB_W] != '0) begin
                r_out.prob <= {PROB_W{1'b1}};
            end else begin
                r_out.prob <= w_quo[PROB_W-1:0];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

[src/row_softmax_engine.sv]
// Load: a load at index row_length-1 starts a row pass, which for each entry does
// a store read, exp setup, one exp step per table bit and a write.
// Read: a store read, the bit-serial divider and an output load with a divide; only
// the output load without. One item at a time; a waiting result does not block loads.
// Reset (synchronous, active low) clears control state; the stores need no clearing
// pass, so the block takes items from the first cycle after reset.
// ----------------------------------------------------------------------------
// Row softmax engine
// Numerically stable fixed-point softmax over one row with an APB config port.
// ----------------------------------------------------------------------------
`include "row_softmax_engine_defines.svh"

module row_softmax_engine #(
    parameter int MAX_ROW_LEN    = rse_pkg::DEF_MAX_ROW_LEN,
    parameter int EXP_TABLE_BITS = rse_pkg::DEF_EXP_TABLE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input item channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rse_pkg::t_in_item              i_in_data,
    // Result item channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rse_pkg::t_out_item             o_out_data,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rse_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rse_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rse_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import rse_pkg::*;

    logic [LEN_REG_W-1:0] r_row_length;
    t_cmd                 w_cmd;
    t_st                  w_st;

    // Config: one register, word index taken from the top address bit.
    // Writes complete in the access phase; no wait states.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ROW_LEN_RESET;
        end else if (psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_ROW_LEN)) begin
            r_row_length <= pwdata[LEN_REG_W-1:0];
        end
    end

    // Read back the row length; anything else reads as zero
    assign prdata = (paddr[APB_ADDR_W-1] == REG_ROW_LEN) ? APB_DATA_W'(r_row_length) : '0;

    // Sequencer: accepts an item only when idle, steps the pass and the divide
    rse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    // Datapath: stores, running max, exp unit, row sum, divider, output register
    rse_dp #(
        .MAX_ROW_LEN    (MAX_ROW_LEN),
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (i_in_data),
        .i_row_length (r_row_length),
        .i_cmd        (w_cmd),
        .o_st         (w_st),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    // Never divide by an empty row sum
    `RSE_ASSERT_IMP(a_div_sum_nz, i_clk, i_rst_n, w_cmd.div_start, w_st.sum_nz, "divide by zero sum")
    // Never overwrite a result still waiting to be taken
    `RSE_ASSERT_IMP(a_out_free, i_clk, i_rst_n, w_cmd.out_load, w_st.out_free, "result overwritten")
    // A read before any completed row carries a zero probability
    `RSE_ASSERT_IMP(a_nr_zero, i_clk, i_rst_n, o_out_valid && o_out_data.not_ready, o_out_data.prob == '0, "not_ready with nonzero prob")
    // Loading the last entry of a row drops ready for the pass
    `RSE_ASSERT_NXT(a_pass_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && w_st.in_load && w_st.in_last, !o_in_ready, "pass did not start")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row softmax engine testbench
// Loads rows of Q7.8 samples over the item channel, reads back normalised
// probabilities and checks each result item against a fixed-point predictor
// kept in step with every accepted item and every row length write.
// ----------------------------------------------------------------------------
module tb;
    import rse_pkg::*;

    localparam int ROWS_MAX    = 1024;
    localparam int HOLD_CYCLES = 3000;
    localparam int DOG_LIMIT   = 200000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    row_softmax_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock: 10 ns period, low first so no rising edge falls at time zero
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor state: a mirror of the block's stores and registers
    // ------------------------------------------------------------------
    logic [15:0]        mdl_samples [ROWS_MAX];
    logic [15:0]        mdl_exps    [ROWS_MAX];
    logic signed [16:0] mdl_max;
    logic [SUM_W-1:0]   mdl_sum;
    logic               mdl_done;
    logic [10:0]        mdl_row_len;

    t_in_item  item_queue[$];      // items waiting for the driver
    t_out_item prob_expect_q[$];   // results still owed by the block

    int  fail_count;
    int  loads_seen;
    int  reads_seen;
    int  passes_seen;
    int  cyc;
    logic hold_req;
    logic timed_out;

    // exp(-d/256) in Q0.16, built from per-bit Q0.32 factors
    function automatic logic [15:0] exp_of_gap(int unsigned gap);
        logic [63:0] acc;
        logic [63:0] fac;
        logic [63:0] r;
        int unsigned g;
        acc = 64'd1 << 32;
        fac = 64'd4278222805;
        g = (gap >> (EXP_SPAN_BITS - DEF_EXP_TABLE_BITS))
            << (EXP_SPAN_BITS - DEF_EXP_TABLE_BITS);
        if (g >= 4096) return 16'd0;
        for (int b = 0; b < EXP_SPAN_BITS; b++) begin
            if (g[b]) acc = (acc * fac + 64'h8000_0000) >> 32;
            fac = (fac * fac + 64'h8000_0000) >> 32;
        end
        r = (acc + 64'h8000) >> 16;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic int eff_len(logic [10:0] raw);
        if (raw == 0) return 1;
        if (raw > ROWS_MAX) return ROWS_MAX;
        return int'(raw);
    endfunction

    // Advance the predictor by one accepted item
    task automatic softmax_predict(input t_in_item it);
        int          len;
        int          gap;
        logic [31:0] acc_sum;
        logic [15:0] e;
        logic [63:0] p;
        t_out_item   res;
        len = eff_len(mdl_row_len);
        if (it.req_type == REQ_LOAD) begin
            loads_seen++;
            mdl_samples[it.elem_index] = it.sample;
            if ($signed({it.sample[15], it.sample}) > mdl_max)
                mdl_max = $signed({it.sample[15], it.sample});
            if (it.elem_index == len - 1) begin
                acc_sum = 0;
                for (int i = 0; i < len; i++) begin
                    gap = mdl_max - $signed({mdl_samples[i][15], mdl_samples[i]});
                    e = exp_of_gap(gap < 0 ? 0 : gap);
                    mdl_exps[i] = e;
                    acc_sum += e;
                    if (acc_sum > 32'h07FF_FFFF) acc_sum = 32'h07FF_FFFF;
                end
                mdl_sum  = acc_sum[SUM_W-1:0];
                mdl_done = 1'b1;
                mdl_max  = -17'sd32768;
                passes_seen++;
            end
        end else begin
            reads_seen++;
            res.prob         = '0;
            res.result_index = it.elem_index;
            res.not_ready    = !mdl_done;
            if (mdl_done && mdl_sum != 0) begin
                p = ((64'(mdl_exps[it.elem_index]) << 16) + 64'(mdl_sum >> 1)) / 64'(mdl_sum);
                res.prob = (p > 64'd65535) ? 16'hFFFF : p[15:0];
            end
            prob_expect_q.push_back(res);
        end
    endtask

    // A long window in which neither side idles
    wire calm = (cyc >= 20000) && (cyc < 32000);

    // ------------------------------------------------------------------
    // Driver: offer queued items, hold each until accepted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) softmax_predict(i_in_data);
            if (!i_in_valid || o_in_ready) begin
                if (item_queue.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
                    i_in_data  <= item_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, one long hold-off, compare results
    // ------------------------------------------------------------------
    int hold_left;
    logic hold_taken;
    int dog;

    always @(posedge i_clk) begin
        t_out_item want;
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left   <= 0;
            hold_taken  <= 1'b0;
            dog         <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (prob_expect_q.size() == 0) begin
                    $display("%0t: unexpected result item idx=%0d prob=%0d nr=%0b", $time,
                             o_out_data.result_index, o_out_data.prob, o_out_data.not_ready);
                    fail_count++;
                end else begin
                    want = prob_expect_q.pop_front();
                    if (want.prob !== o_out_data.prob) begin
                        $display("%0t: prob mismatch expected %0d actual %0d (idx %0d)",
                                 $time, want.prob, o_out_data.prob, want.result_index);
                        fail_count++;
                    end
                    if (want.result_index !== o_out_data.result_index) begin
                        $display("%0t: result_index mismatch expected %0d actual %0d",
                                 $time, want.result_index, o_out_data.result_index);
                        fail_count++;
                    end
                    if (want.not_ready !== o_out_data.not_ready) begin
                        $display("%0t: not_ready mismatch expected %0b actual %0b",
                                 $time, want.not_ready, o_out_data.not_ready);
                        fail_count++;
                    end
                end
            end
            // hold off once for a long stretch while the sender keeps going
            if (hold_req && !hold_taken) begin
                hold_taken  <= 1'b1;
                hold_left   <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 22);
            end
            // watchdog: count stuck cycles while work is outstanding
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel
                || hold_left > 0)
                dog <= 0;
            else if (i_in_valid || prob_expect_q.size() > 0)
                dog <= dog + 1;
            if (dog >= DOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, DOG_LIMIT);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation, with its own record of what has been written
    // ------------------------------------------------------------------
    logic        gen_written [ROWS_MAX];
    logic        gen_done;
    int          gen_len;
    int          gen_row_len;   // length of the last completed row
    int          queued;

    task automatic push_load(input int idx, input logic [15:0] smp);
        t_in_item it;
        it.req_type   = REQ_LOAD;
        it.elem_index = IDX_W'(idx);
        it.sample     = smp;
        item_queue.push_back(it);
        gen_written[idx] = 1'b1;
        if (idx == gen_len - 1) begin
            gen_done    = 1'b1;
            gen_row_len = gen_len;
        end
        queued++;
    endtask

    task automatic push_read(input int idx);
        t_in_item it;
        it.req_type   = REQ_READ;
        it.elem_index = IDX_W'(idx);
        it.sample     = 16'($urandom);
        item_queue.push_back(it);
        queued++;
    endtask

    // Read somewhere safe: anywhere before the first row, else inside the last row
    task automatic push_safe_read();
        if (!gen_done) push_read($urandom_range(ROWS_MAX - 1));
        else push_read($urandom_range(gen_row_len - 1));
    endtask

    function automatic logic [15:0] pick_sample(input logic [15:0] base);
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            default: return base + 16'($urandom_range(1536)) - 16'd768;
        endcase
    endfunction

    // Pause the sender until every result is back, then let a pass finish
    task automatic drain(input int extra);
        wait (item_queue.size() == 0 && !i_in_valid && prob_expect_q.size() == 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_row_len(input logic [10:0] val);
        drain(eff_len(mdl_row_len) * 16 + 100);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(REG_ROW_LEN) << 2;
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mdl_row_len = val;
        gen_len     = eff_len(val);
    endtask

    // One well-formed row: every entry in random order, the last index last
    task automatic push_row();
        int          order [$];
        int          j;
        int          tmp;
        logic [15:0] base;
        base = 16'($urandom);
        for (int i = 0; i < gen_len - 1; i++) order.push_back(i);
        for (int i = order.size() - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[k]) begin
            push_load(order[k], pick_sample(base));
            if ($urandom_range(99) < 15) push_safe_read();
        end
        push_load(gen_len - 1, pick_sample(base));
        repeat ($urandom_range(gen_len / 2 + 1, gen_len + 2)) push_safe_read();
    endtask

    // Load a stray sample that cannot start a pass over unwritten entries
    task automatic push_stray_load();
        int  idx;
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < gen_len - 1; i++) if (!gen_written[i]) ok = 1'b0;
        idx = $urandom_range(ROWS_MAX - 1);
        if (idx == gen_len - 1 && !ok) idx = (idx + 1) % ROWS_MAX;
        if (idx == gen_len - 1 && !ok) idx = (idx + 1) % ROWS_MAX;
        push_load(idx, 16'($urandom));
    endtask

    initial begin
        int phase;
        int lens_used;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cyc         = 0;
        hold_req    = 1'b0;
        fail_count  = 0;
        loads_seen  = 0;
        reads_seen  = 0;
        passes_seen = 0;
        queued      = 0;
        lens_used   = 0;
        gen_done    = 1'b0;
        gen_row_len = 1;
        mdl_max     = -17'sd32768;
        mdl_sum     = '0;
        mdl_done    = 1'b0;
        mdl_row_len = ROW_LEN_RESET;
        gen_len     = eff_len(ROW_LEN_RESET);
        foreach (gen_written[i]) begin
            gen_written[i] = 1'b0;
            mdl_samples[i] = '0;
            mdl_exps[i]    = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // read before any row has finished: not_ready, at both index extremes
        push_read(0);
        push_read(ROWS_MAX - 1);
        // a zero row length acts as one: every load at index 0 runs a pass
        write_row_len(11'd0);
        push_load(ROWS_MAX - 1, 16'h8000);
        push_load(0, 16'h7FFF);
        push_read(0);                    // a single entry saturates to 65535
        push_load(0, 16'h8000);
        push_read(0);
        // the widest gap drives exp to zero
        write_row_len(11'd2);
        push_load(0, 16'h7FFF);
        push_load(1, 16'h8000);
        push_read(0);
        push_read(1);
        // a stale sample above the new maximum clamps its gap to zero
        write_row_len(11'd3);
        push_load(0, 16'h0400);
        push_load(1, 16'hFE00);
        push_load(2, 16'h0000);
        push_read(2);
        push_load(2, 16'hFC00);
        push_read(0);                    // read after the row's second pass
        push_read(1);
        push_read(2);
        drain(200);

        // --- random part: one full-size row, then many short ones ---
        write_row_len(11'd2047);         // saturates to the largest row
        push_row();
        phase = 0;
        while (queued < 1850) begin
            case ($urandom_range(7))
                0:       write_row_len(11'd1);
                1:       write_row_len(11'($urandom_range(48, 96)));
                default: write_row_len(11'($urandom_range(2, 40)));
            endcase
            lens_used++;
            if (phase == 0) hold_req <= 1'b1;
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(3) == 0) push_stray_load();
                push_row();
            end
            phase++;
        end
        write_row_len(11'd1024);

        drain(ROWS_MAX * 16 + 100);
        $display("Covered %0d loads, %0d reads, %0d row passes over %0d row lengths,",
                 loads_seen, reads_seen, passes_seen, lens_used + 5);
        $display("including a full-size row, a long result hold-off and not_ready reads.");
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
